>>> sv/ablm_pkg.sv
`timescale 1ns / 1ps

package ablm_pkg;

  localparam int RING_DEPTH_DEF = 512;
  localparam int SAMPLE_W       = 16;
  localparam int LEVEL_W        = 17;
  localparam int OUT_TDATA_W    = 40;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LEVEL_W-1:0]  level_t;

endpackage

>>> sv/audio_band_level_meter.sv
`timescale 1ns / 1ps

// channel  | signals                          | contents
// ---------+----------------------------------+------------------------------------
// in       | s_tvalid s_tready s_tdata s_tlast | sample word, tlast = end of batch
// out      | m_tvalid m_tready m_tdata         | low level and high level word
//
// a word without tlast is written into the ring, words may follow back to back
// a word with tlast keeps s_tready low while the levels are computed:
// one pass over the ring memory (one read a cycle), then one shared multiplier by a
// constant reciprocal, a product step then a quotient step for each level
// the final state repeats while an earlier level word still waits for m_tready
// after reset a clearing pass writes zeros over the whole ring, s_tready low
// a waiting result in the output register does not block plain words

module audio_band_level_meter
  import ablm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // sample[15:0]
  input  logic                   s_tlast,   // end_of_batch
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // low_level[16:0], high_level[33:17], zeros
);

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int SUM_W  = SAMPLE_W + ADDR_W + 1;
  localparam int NUM_W  = SUM_W + 4;

  // floor(x / d) as (x * rcp) >> sh, exact for every x below (LEVEL_ONE + 1) * d;
  // larger numerators saturate anyway
  localparam longint SAT_N  = longint'(LEVEL_ONE) + 1;
  localparam longint LIM_LO = SAT_N * RING_DEPTH;
  localparam longint LIM_HI = SAT_N * (RING_DEPTH - 2);
  localparam int     SH_LO  = $clog2(LIM_LO * RING_DEPTH);
  localparam int     SH_HI  = $clog2(LIM_HI * (RING_DEPTH - 2));
  localparam longint RCP_LO = ((longint'(1) << SH_LO) + RING_DEPTH - 1) / RING_DEPTH;
  localparam longint RCP_HI = ((longint'(1) << SH_HI) + RING_DEPTH - 3) / (RING_DEPTH - 2);
  localparam int     XC_W   = $clog2(LIM_LO);
  localparam int     RCP_W  = $clog2(((RCP_LO > RCP_HI) ? RCP_LO : RCP_HI) + 1);
  localparam int     PROD_W = XC_W + RCP_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_QUO   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [ADDR_W-1:0] wpos;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              issue_on;
  logic              d_valid;
  logic [ADDR_W-1:0] d_idx;
  sample_t           prev1;
  sample_t           prev2;
  logic [SUM_W-1:0]  low_sum;
  logic [SUM_W-1:0]  diff_sum;
  logic              div_hi;
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic              over;
  level_t            lo_q;
  level_t            hi_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  sample_t           ram_wdata;
  sample_t           rdata;

  logic              accept;
  logic              out_load;
  logic [16:0]       abs_x;
  logic [16:0]       diff;
  logic [16:0]       abs_d;
  logic [SUM_W-1:0]  low_sum_next;
  logic [SUM_W-1:0]  diff_sum_next;
  logic [XC_W-1:0]   mul_a;
  logic [RCP_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod_next;
  logic              over_next;
  level_t            quo;
  level_t            q_sat;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  assign ram_we    = (state == S_CLEAR) || accept;
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : wpos;
  assign ram_wdata = (state == S_CLEAR) ? '0 : s_tdata;

  ablm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // accumulate for the entry whose read data is present
  always_comb begin
    abs_x         = rdata[15] ? 17'(-{rdata[15], rdata}) : {1'b0, rdata};
    diff          = {rdata[15], rdata} - {prev2[15], prev2};
    abs_d         = diff[16] ? 17'(-diff) : diff;
    low_sum_next  = low_sum;
    diff_sum_next = diff_sum;
    if (d_valid) begin
      if (d_idx[1:0] == 2'b00) begin
        low_sum_next = low_sum + SUM_W'(abs_x);
      end
      if (d_idx >= ADDR_W'(2)) begin
        diff_sum_next = diff_sum + SUM_W'(abs_d);
      end
    end
  end

  // shared reciprocal multiplier
  always_comb begin
    over_next = div_hi ? (num >= NUM_W'(LIM_HI)) : (num >= NUM_W'(LIM_LO));
    mul_a     = num[XC_W-1:0];
    mul_b     = div_hi ? RCP_W'(RCP_HI) : RCP_W'(RCP_LO);
    prod_next = {{RCP_W{1'b0}}, mul_a} * {{XC_W{1'b0}}, mul_b};
    quo       = div_hi ? level_t'(prod >> SH_HI) : level_t'(prod >> SH_LO);
    q_sat     = over ? LEVEL_ONE : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      wpos     <= '0;
      clr_addr <= '0;
      rd_addr  <= '0;
      issue_on <= 1'b0;
      d_valid  <= 1'b0;
      div_hi   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(OUT_TDATA_W - 2 * LEVEL_W){1'b0}}, hi_q, lo_q};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            wpos <= (wpos == LAST_ADDR) ? '0 : wpos + 1'b1;
            if (s_tlast) begin
              state    <= S_WALK;
              rd_addr  <= '0;
              issue_on <= 1'b1;
              d_valid  <= 1'b0;
              low_sum  <= '0;
              diff_sum <= '0;
              prev1    <= '0;
              prev2    <= '0;
            end
          end
        end
        S_WALK: begin
          d_valid <= issue_on;
          d_idx   <= rd_addr;
          if (issue_on) begin
            if (rd_addr == LAST_ADDR) begin
              issue_on <= 1'b0;
            end else begin
              rd_addr <= rd_addr + 1'b1;
            end
          end
          if (d_valid) begin
            low_sum  <= low_sum_next;
            diff_sum <= diff_sum_next;
            prev1    <= rdata;
            prev2    <= prev1;
            if (d_idx == LAST_ADDR) begin
              state   <= S_MUL;
              d_valid <= 1'b0;
              div_hi  <= 1'b0;
              num     <= {low_sum_next, 4'b0000};
            end
          end
        end
        S_MUL: begin
          prod  <= prod_next;
          over  <= over_next;
          state <= S_QUO;
        end
        S_QUO: begin
          if (!div_hi) begin
            lo_q   <= q_sat;
            div_hi <= 1'b1;
            num    <= {3'b000, diff_sum, 1'b0};
            state  <= S_MUL;
          end else begin
            hi_q  <= q_sat;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/ablm_ram.sv
`timescale 1ns / 1ps

module ablm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
